// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define CBH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cbh check failed");

// clocked check that also holds during reset
`define CBH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cbh reset check failed");

`endif

// File: rtl/core/cbh_pkg.sv
// shared constants, types and helpers of the cumulative bucket histogram
package cbh_pkg;

  localparam int unsigned NUM_BUCKETS = 8;
  localparam int unsigned HW_BUCKETS  = 8;
  localparam int unsigned IDX_W       = $clog2(HW_BUCKETS);
  localparam int unsigned ADDR_W      = IDX_W + 2;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned SMP_W       = 32;
  localparam int unsigned SUM_W       = 64;

  localparam logic [CNT_W-1:0] CntMax      = {CNT_W{1'b1}};
  localparam logic [SMP_W-1:0] BoundReset  = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SumPosMax   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SumNegMin   = {1'b1, {(SUM_W-1){1'b0}}};

  // record that travels down the chain of cells
  typedef struct packed {
    logic signed [SMP_W-1:0]            sample;
    logic [CNT_W-1:0]                   total;
    logic signed [SUM_W-1:0]            sum;
    logic [NUM_BUCKETS-1:0][CNT_W-1:0]  counts;
  } cbh_rec_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == CntMax) ? c : c + 1'b1;
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] r;
    r = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (r[SUM_W-1] != a[SUM_W-1])) begin
      r = b[SUM_W-1] ? SumNegMin : SumPosMax;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/cumulative_bucket_histogram.sv
// top level of the cumulative bucket histogram: bound registers and cell chain
//
// Input channel: sample_i with sample_valid_i / sample_ready_o. Each transfer
// carries one signed Q16.16 sample and yields exactly one result.
// Output channel: count_b0_o..count_b7_o, total_seen_o, sample_sum_o with
// result_valid_o / result_ready_i. A result is the snapshot of all counters
// after its own sample has been applied.
// Config: APB-style port, bound_i at byte address 4*i; the user must write it
// only while idle; the block does not enforce this. One head stage for total
// and sum, then one cell per bucket; the last cell holds the output register.
// Throughput: one sample per cycle; the whole chain advances together, so
// sample_ready_o is high whenever the output register is empty or taken.
// When the receiver stalls the chain freezes in place and the result holds;
// up to NUM_BUCKETS + 1 samples are in flight.
// Reset: asynchronous, active low; clears all tallies, the total, the sum and
// the stage valid bits, and sets every bound to the largest positive value.
// Buckets at or above NUM_BUCKETS always report zero.
module cumulative_bucket_histogram import cbh_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    sample_valid_i,
  output logic                    sample_ready_o,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic                    result_valid_o,
  input  logic                    result_ready_i,
  output logic [CNT_W-1:0]        count_b0_o,
  output logic [CNT_W-1:0]        count_b1_o,
  output logic [CNT_W-1:0]        count_b2_o,
  output logic [CNT_W-1:0]        count_b3_o,
  output logic [CNT_W-1:0]        count_b4_o,
  output logic [CNT_W-1:0]        count_b5_o,
  output logic [CNT_W-1:0]        count_b6_o,
  output logic [CNT_W-1:0]        count_b7_o,
  output logic [CNT_W-1:0]        total_seen_o,
  output logic signed [SUM_W-1:0] sample_sum_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [SMP_W-1:0]                bound_q [HW_BUCKETS];
  logic [IDX_W-1:0]                reg_idx;
  logic                            adv;
  logic [NUM_BUCKETS:0]            stage_valid;
  cbh_rec_t                        stage_rec [NUM_BUCKETS+1];
  logic [HW_BUCKETS-1:0][CNT_W-1:0] counts_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign prdata  = bound_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HW_BUCKETS; i++) begin
        bound_q[i] <= BoundReset;
      end
    end else if (psel && penable && pwrite && pready) begin
      bound_q[reg_idx] <= pwdata[SMP_W-1:0];
    end
  end

  // the chain moves when the output register is empty or being taken
  assign adv            = !stage_valid[NUM_BUCKETS] || result_ready_i;
  assign sample_ready_o = adv;

  cbh_head u_head (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sample_valid_i),
    .sample_i(sample_i),
    .valid_o (stage_valid[0]),
    .rec_o   (stage_rec[0])
  );

  for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
    cbh_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(stage_valid[i]),
      .rec_i  (stage_rec[i]),
      .bound_i(bound_q[i]),
      .valid_o(stage_valid[i+1]),
      .rec_o  (stage_rec[i+1])
    );
  end

  for (genvar i = 0; i < HW_BUCKETS; i++) begin : g_out
    if (i < NUM_BUCKETS) begin : g_used
      assign counts_out[i] = stage_rec[NUM_BUCKETS].counts[i];
    end else begin : g_unused
      assign counts_out[i] = '0;
    end
  end

  assign result_valid_o = stage_valid[NUM_BUCKETS];
  assign count_b0_o     = counts_out[0];
  assign count_b1_o     = counts_out[1];
  assign count_b2_o     = counts_out[2];
  assign count_b3_o     = counts_out[3];
  assign count_b4_o     = counts_out[4];
  assign count_b5_o     = counts_out[5];
  assign count_b6_o     = counts_out[6];
  assign count_b7_o     = counts_out[7];
  assign total_seen_o   = stage_rec[NUM_BUCKETS].total;
  assign sample_sum_o   = stage_rec[NUM_BUCKETS].sum;

endmodule

// File: rtl/core/cbh_head.sv
// head stage: total count and saturating running sum, starts the record
module cbh_head import cbh_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic                    valid_o,
  output cbh_rec_t                rec_o
);

  logic [CNT_W-1:0] total_q, total_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             valid_q;
  cbh_rec_t         rec_q, rec_d;
  logic             take;

  assign take = adv_i && valid_i;

  always_comb begin
    total_d = take ? sat_inc(total_q) : total_q;
    sum_d   = take ? sat_add(sum_q, {{(SUM_W-SMP_W){sample_i[SMP_W-1]}}, sample_i})
                   : sum_q;
    rec_d        = rec_q;
    rec_d.sample = sample_i;
    rec_d.total  = total_d;
    rec_d.sum    = sum_d;
    rec_d.counts = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      total_q <= total_d;
      sum_q   <= sum_d;
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rec_q <= rec_d;
    end
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule

// File: rtl/core/cbh_cell.sv
// one bucket cell: compare against its bound, bump its tally, pass the record on
module cbh_cell import cbh_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  cbh_rec_t                rec_i,
  input  logic signed [SMP_W-1:0] bound_i,
  output logic                    valid_o,
  output cbh_rec_t                rec_o
);

  logic [CNT_W-1:0] tally_q, tally_d;
  logic             valid_q;
  cbh_rec_t         rec_q, rec_d;
  logic             hit;

  assign hit = valid_i && (rec_i.sample <= bound_i);

  always_comb begin
    tally_d = (adv_i && hit) ? sat_inc(tally_q) : tally_q;
    // shift earlier counts down, this cell's count enters at the top
    rec_d = rec_i;
    for (int k = 0; k < NUM_BUCKETS - 1; k++) begin
      rec_d.counts[k] = rec_i.counts[k+1];
    end
    rec_d.counts[NUM_BUCKETS-1] = tally_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      tally_q <= tally_d;
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rec_q <= rec_d;
    end
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule

// File: rtl/core/cbh_checker.sv
// port-level checks on the cumulative bucket histogram, bound to the top level
`include "assert_macros.svh"

module cbh_checker import cbh_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    sample_ready_o,
  input logic                    result_valid_o,
  input logic                    result_ready_i,
  input logic [CNT_W-1:0]        count_b0_o,
  input logic [CNT_W-1:0]        total_seen_o,
  input logic signed [SUM_W-1:0] sample_sum_o
);

  // registers may still be unknown at the very first edge, so the check looks at the next edge
  `CBH_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |=> !result_valid_o)

  `CBH_ASSERT(a_ready_follows_output, sample_ready_o == (!result_valid_o || result_ready_i))

  `CBH_ASSERT(a_bucket_within_total, result_valid_o |-> count_b0_o <= total_seen_o)

  `CBH_ASSERT(a_stall_holds, result_valid_o && !result_ready_i |=> result_valid_o && $stable(total_seen_o) && $stable(sample_sum_o))

endmodule

bind cumulative_bucket_histogram cbh_checker u_cbh_checker (.*);

// File: dv/tb_cumulative_bucket_histogram.sv
// self-checking testbench of the cumulative bucket histogram
module tb_cumulative_bucket_histogram;
  timeunit 1ns;
  timeprecision 1ps;
  import cbh_pkg::*;

  localparam int unsigned LATENCY     = NUM_BUCKETS + 1;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned HEAVY_PCT   = 80;
  localparam int unsigned LIGHT_PCT   = 11;
  localparam int          SMP_MIN     = 32'sh8000_0000;
  localparam int          SMP_MAX     = 32'sh7FFF_FFFF;
  localparam int          ONE_Q16     = 32'sh0001_0000;

  typedef struct packed {
    logic [HW_BUCKETS-1:0][CNT_W-1:0] counts;
    logic [CNT_W-1:0]                 total;
    logic [SUM_W-1:0]                 sum;
  } hist_snapshot_t;

  class hist_scoreboard;
    logic signed [SMP_W-1:0] bounds[HW_BUCKETS];
    logic [CNT_W-1:0]        hit_tally[HW_BUCKETS];
    logic [CNT_W-1:0]        samples_seen;
    logic [SUM_W-1:0]        sample_total;
    hist_snapshot_t          pending_snapshots[$];
    int unsigned             mismatches;

    function new();
      for (int i = 0; i < HW_BUCKETS; i++) begin
        bounds[i]    = BoundReset;
        hit_tally[i] = '0;
      end
      samples_seen = '0;
      sample_total = '0;
      mismatches   = 0;
    endfunction

    function void set_bound(int unsigned idx, logic [SMP_W-1:0] value);
      if (idx < HW_BUCKETS) bounds[idx] = value;
    endfunction

    function int unsigned pending();
      return pending_snapshots.size();
    endfunction

    // accepted sample: update tallies and queue the snapshot it must produce
    function void apply_sample(logic signed [SMP_W-1:0] s);
      logic signed [SUM_W:0] acc;
      hist_snapshot_t        snap;
      for (int i = 0; i < HW_BUCKETS; i++) begin
        if (i < NUM_BUCKETS && s <= bounds[i] && hit_tally[i] != CntMax)
          hit_tally[i] = hit_tally[i] + 1'b1;
      end
      if (samples_seen != CntMax) samples_seen = samples_seen + 1'b1;
      acc = {sample_total[SUM_W-1], sample_total} + {{(SUM_W-SMP_W+1){s[SMP_W-1]}}, s};
      // a carry into the guard bit that differs from the sign means overflow
      if (acc[SUM_W] != acc[SUM_W-1]) sample_total = acc[SUM_W] ? SumNegMin : SumPosMax;
      else sample_total = acc[SUM_W-1:0];
      for (int i = 0; i < HW_BUCKETS; i++)
        snap.counts[i] = (i < NUM_BUCKETS) ? hit_tally[i] : '0;
      snap.total = samples_seen;
      snap.sum   = sample_total;
      pending_snapshots = {pending_snapshots, snap};
    endfunction

    function void compare_snapshot(hist_snapshot_t got);
      hist_snapshot_t want;
      if (pending_snapshots.size() == 0) begin
        $error("result transfer with no sample outstanding");
        mismatches++;
        return;
      end
      want = pending_snapshots.pop_front();
      for (int i = 0; i < HW_BUCKETS; i++) begin
        if (got.counts[i] !== want.counts[i]) begin
          $error("count_b%0d: expected %0d, got %0d", i, want.counts[i], got.counts[i]);
          mismatches++;
        end
      end
      if (got.total !== want.total) begin
        $error("total_seen: expected %0d, got %0d", want.total, got.total);
        mismatches++;
      end
      if (got.sum !== want.sum) begin
        $error("sample_sum: expected %0d, got %0d", $signed(want.sum), $signed(got.sum));
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    sample_valid_i = 1'b0;
  logic                    sample_ready_o;
  logic signed [SMP_W-1:0] sample_i       = '0;
  logic                    result_valid_o;
  logic                    result_ready_i = 1'b0;
  logic [CNT_W-1:0]        count_b0_o, count_b1_o, count_b2_o, count_b3_o;
  logic [CNT_W-1:0]        count_b4_o, count_b5_o, count_b6_o, count_b7_o;
  logic [CNT_W-1:0]        total_seen_o;
  logic signed [SUM_W-1:0] sample_sum_o;
  logic                    psel           = 1'b0;
  logic                    penable        = 1'b0;
  logic                    pwrite         = 1'b0;
  logic [ADDR_W-1:0]       paddr          = '0;
  logic [31:0]             pwdata         = '0;
  logic [31:0]             prdata;
  logic                    pready;

  hist_scoreboard sb = new();
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  logic           hold_active    = 1'b0;
  event           hold_start;
  int             bound_plan[HW_BUCKETS];

  cumulative_bucket_histogram u_top (
    .clk_i, .rst_ni,
    .sample_valid_i, .sample_ready_o, .sample_i,
    .result_valid_o, .result_ready_i,
    .count_b0_o, .count_b1_o, .count_b2_o, .count_b3_o,
    .count_b4_o, .count_b5_o, .count_b6_o, .count_b7_o,
    .total_seen_o, .sample_sum_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off while the sender keeps going
  always @(posedge clk_i)
    result_ready_i <= hold_active ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

  initial forever begin
    @(hold_start);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  always @(posedge clk_i) begin : monitor
    hist_snapshot_t got;
    if (rst_ni) begin
      if (sample_valid_i && sample_ready_o) sb.apply_sample(sample_i);
      if (result_valid_o && result_ready_i) begin
        got.counts = {count_b7_o, count_b6_o, count_b5_o, count_b4_o,
                      count_b3_o, count_b2_o, count_b1_o, count_b0_o};
        got.total  = total_seen_o;
        got.sum    = sample_sum_o;
        sb.compare_snapshot(got);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni || (sample_valid_i && sample_ready_o) || (result_valid_o && result_ready_i))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("cumulative_bucket_histogram regression: fail");
      $finish;
    end
  end

  task automatic send_sample(input int s);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) begin
        sample_valid_i <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (!sample_ready_o);
  endtask

  // one apb transfer; the bus is released by the caller once the sequence ends
  task automatic apb_xfer(input bit wr, input int unsigned idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic program_bounds();
    logic [31:0] rd;
    for (int i = 0; i < HW_BUCKETS; i++) begin
      apb_xfer(1'b1, i, bound_plan[i], rd);
      sb.set_bound(i, bound_plan[i]);
    end
    for (int i = 0; i < HW_BUCKETS; i++) begin
      apb_xfer(1'b0, i, '0, rd);
      if (rd !== 32'(bound_plan[i])) begin
        $error("bound_%0d readback: expected %h, got %h", i, 32'(bound_plan[i]), rd);
        sb.mismatches++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic int pick_sample();
    int unsigned r;
    int          off;
    r = $urandom_range(99);
    if (r < 40) begin
      // land on or next to one of the live bounds
      off = int'($urandom_range(4)) - 2;
      return sb.bounds[$urandom_range(HW_BUCKETS-1)] + off;
    end
    if (r < 70) return $urandom;
    if (r < 85) begin
      case ($urandom_range(3))
        0:       return SMP_MIN;
        1:       return SMP_MAX;
        2:       return 0;
        default: return -1;
      endcase
    end
    return int'($urandom_range(32 * ONE_Q16)) - 16 * ONE_Q16;
  endfunction

  task automatic send_random(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) send_sample(pick_sample());
  endtask

  task automatic sort_plan();
    int t;
    for (int i = 1; i < HW_BUCKETS; i++)
      for (int j = i; j > 0 && bound_plan[j-1] > bound_plan[j]; j--) begin
        t = bound_plan[j];
        bound_plan[j] = bound_plan[j-1];
        bound_plan[j-1] = t;
      end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset bounds: every bucket takes everything up to the largest value
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(0);
    send_sample(-1);
    send_sample(1);
    send_sample(32'sh0001_8000);
    send_random(140);
    drain();

    // ordinary latency-style bounds
    bound_plan = '{-4 * ONE_Q16, -ONE_Q16, 0, ONE_Q16 / 2, ONE_Q16, 2 * ONE_Q16,
                   8 * ONE_Q16, 100 * ONE_Q16};
    program_bounds();
    send_idle_pct  = HEAVY_PCT;
    recv_stall_pct = 0;
    send_random(150);
    drain();

    // bounds spread over the whole range, lowest and highest included
    for (int i = 0; i < HW_BUCKETS; i++) bound_plan[i] = SMP_MIN + i * 613566756;
    bound_plan[HW_BUCKETS-1] = SMP_MAX;
    program_bounds();
    send_idle_pct  = 0;
    recv_stall_pct = HEAVY_PCT;
    send_sample(SMP_MIN);
    send_sample(SMP_MIN + 1);
    send_sample(SMP_MAX);
    send_sample(SMP_MAX - 1);
    send_sample(0);
    send_sample(-1);
    for (int i = 1; i < HW_BUCKETS - 1; i++) begin
      send_sample(bound_plan[i]);
      send_sample(bound_plan[i] + 1);
    end
    send_random(150);
    drain();

    // random increasing bounds
    for (int i = 0; i < HW_BUCKETS; i++) bound_plan[i] = $urandom;
    sort_plan();
    program_bounds();
    send_idle_pct  = LIGHT_PCT;
    recv_stall_pct = LIGHT_PCT;
    send_random(150);
    drain();

    // bounds packed at the bottom; receiver holds off so the chain backs up
    for (int i = 0; i < HW_BUCKETS; i++) bound_plan[i] = SMP_MIN + i;
    program_bounds();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_start;
    send_random(100);
    drain();

    // misordered bounds: each bucket decided by its own bound only
    for (int i = 0; i < HW_BUCKETS; i++) bound_plan[i] = $urandom;
    program_bounds();
    send_idle_pct  = HEAVY_PCT;
    recv_stall_pct = HEAVY_PCT;
    send_random(130);
    drain();

    // bounds packed at the top
    for (int i = 0; i < HW_BUCKETS; i++) bound_plan[i] = SMP_MAX - (HW_BUCKETS - 1) + i;
    program_bounds();
    send_idle_pct  = LIGHT_PCT;
    recv_stall_pct = HEAVY_PCT;
    send_random(100);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("cumulative_bucket_histogram regression: pass");
    else
      $display("cumulative_bucket_histogram regression: fail");
    $finish;
  end

endmodule

// File: cumulative_bucket_histogram.f
+incdir+rtl/core
rtl/core/cbh_pkg.sv
rtl/core/cbh_head.sv
rtl/core/cbh_cell.sv
rtl/core/cumulative_bucket_histogram.sv
rtl/core/cbh_checker.sv
dv/tb_cumulative_bucket_histogram.sv
